### hdl/ale_pkg.sv
// Shared types and constants of the array linked list engine.
// Used by the interfaces, the walk unit, the top level and the checker.
package ale_pkg;

    // Node store size; the slot index needs one code more for the null marker.
    localparam int NODE_COUNT = 16;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int IDX_W      = $clog2(NODE_COUNT + 1);

    localparam int OP_W     = 3;
    localparam int ELEM_W   = 8;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = (IDX_W > POS_W) ? IDX_W : POS_W;

    localparam logic [IDX_W-1:0] NIL = IDX_W'(NODE_COUNT);

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT  = 3'd0,
        OP_INS_REAR   = 3'd1,
        OP_INS_AT     = 3'd2,
        OP_INS_SORTED = 3'd3,
        OP_DEL_FRONT  = 3'd4,
        OP_DEL_REAR   = 3'd5,
        OP_DEL_AT     = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Everything the walk unit looks at for one link of a walk.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [ELEM_W-1:0] elem;
        logic [POS_W-1:0]         pos;
        logic [IDX_W-1:0]         n;
        logic [IDX_W-1:0]         cur;
        logic [IDX_W-1:0]         link;
        logic signed [ELEM_W-1:0] value;
    } walk_in_t;

endpackage

### hdl/ale_req_if.sv
// Request channel of the linked list engine: valid, ready and one operation.
// Depends on ale_pkg for the field widths.
interface ale_req_if;
    logic                              valid;
    logic                              ready;
    logic [ale_pkg::OP_W-1:0]          operation;
    logic signed [ale_pkg::ELEM_W-1:0] element;
    logic [ale_pkg::POS_W-1:0]         position;

    modport source (output valid, output operation, output element, output position,
                    input ready);
    modport sink   (input valid, input operation, input element, input position,
                    output ready);
endinterface

### hdl/ale_rsp_if.sv
// Response channel of the linked list engine: valid, ready and one result.
// Depends on ale_pkg for the field widths.
interface ale_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ale_pkg::STATUS_W-1:0]      status;
    logic [ale_pkg::IDX_W-1:0]         slot_index;
    logic signed [ale_pkg::ELEM_W-1:0] removed_value;

    modport source (output valid, output status, output slot_index, output removed_value,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input removed_value,
                    output ready);
endinterface

### hdl/array_linked_list_engine_core.sv
// Top level of the array linked list engine: sequencer, head registers and node store.
// Depends on ale_pkg, ale_req_if, ale_rsp_if, ale_ram and ale_walk_unit.
//
// A singly linked list of signed bytes lives in a node store of NODE_COUNT slots,
// with unused slots chained on a free list. Each transfer on req asks for one
// operation (insert front, rear, at position or sorted; delete front, rear or
// at position) and yields exactly one transfer on rsp with the status, the slot
// taken or freed, and the removed value.
// The walk along the list reads one link per cycle from the link memory; an
// operation passes no link for front operations and up to NODE_COUNT - 1 links
// otherwise. The next request is taken in the cycle after the result is
// registered. A full store or empty list is answered without a walk.
// After reset the block chains every slot into the free list and holds
// req.ready low meanwhile.
// The result waits in an output register; a new request is accepted while it
// waits, and a finished operation holds its result until rsp.ready frees the
// register.
module array_linked_list_engine_core (
    input  logic      clk,
    input  logic      rst_n,
    ale_req_if.sink   req,
    ale_rsp_if.source rsp
);

    localparam int AW = ale_pkg::ADDR_W;
    localparam int IW = ale_pkg::IDX_W;
    localparam int EW = ale_pkg::ELEM_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_INS_A,
        S_INS_B,
        S_DEL_A,
        S_DEL_B,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              init_cnt_reg, init_cnt_next;
    logic [ale_pkg::OP_W-1:0]   op_reg, op_next;
    logic signed [EW-1:0]       elem_reg, elem_next;
    logic [ale_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [IW-1:0]              prev_reg, prev_next;
    logic [IW-1:0]              cur_reg, cur_next;
    logic [IW-1:0]              n_reg, n_next;
    logic [IW-1:0]              nxt_reg, nxt_next;
    logic signed [EW-1:0]       val_reg, val_next;
    logic [IW-1:0]              list_head_reg, list_head_next;
    logic [IW-1:0]              free_head_reg, free_head_next;
    logic [ale_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IW-1:0]              slot_reg, slot_next;
    logic signed [EW-1:0]       removed_reg, removed_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic [ale_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [IW-1:0]              rsp_slot_reg, rsp_slot_next;
    logic signed [EW-1:0]       rsp_removed_reg, rsp_removed_next;

    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [IW-1:0] link_wdata;
    logic [IW-1:0] link_rd;
    logic          val_we;
    logic [AW-1:0] val_waddr;
    logic [EW-1:0] val_rd;
    logic [AW-1:0] rd_addr;

    ale_pkg::walk_in_t walk;
    logic              advance;
    logic              is_insert;

    ale_ram #(.WIDTH(IW), .DEPTH(ale_pkg::NODE_COUNT)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rd)
    );

    ale_ram #(.WIDTH(EW), .DEPTH(ale_pkg::NODE_COUNT)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (elem_reg),
        .raddr (rd_addr),
        .rdata (val_rd)
    );

    assign walk.op    = op_reg;
    assign walk.elem  = elem_reg;
    assign walk.pos   = pos_reg;
    assign walk.n     = n_reg;
    assign walk.cur   = cur_reg;
    assign walk.link  = link_rd;
    assign walk.value = $signed(val_rd);

    ale_walk_unit u_walk (
        .walk    (walk),
        .advance (advance)
    );

    assign is_insert = op_reg <= ale_pkg::OP_INS_SORTED;

    assign req.ready         = state_reg == S_IDLE;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.slot_index    = rsp_slot_reg;
    assign rsp.removed_value = rsp_removed_reg;

    always_comb
    begin
        state_next       = state_reg;
        init_cnt_next    = init_cnt_reg;
        op_next          = op_reg;
        elem_next        = elem_reg;
        pos_next         = pos_reg;
        prev_next        = prev_reg;
        cur_next         = cur_reg;
        n_next           = n_reg;
        nxt_next         = nxt_reg;
        val_next         = val_reg;
        list_head_next   = list_head_reg;
        free_head_next   = free_head_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;
        removed_next     = removed_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_slot_next    = rsp_slot_reg;
        rsp_removed_next = rsp_removed_reg;

        link_we    = 1'b0;
        link_waddr = cur_reg[AW-1:0];
        link_wdata = '0;
        val_we     = 1'b0;
        val_waddr  = free_head_reg[AW-1:0];
        rd_addr    = list_head_reg[AW-1:0];

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                // Chain slot i to slot i + 1; the last slot gets the null marker.
                link_we    = 1'b1;
                link_waddr = init_cnt_reg;
                link_wdata = IW'(init_cnt_reg) + IW'(1);
                init_cnt_next = init_cnt_reg + AW'(1);
                if (init_cnt_reg == AW'(ale_pkg::NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.operation;
                    elem_next    = req.element;
                    pos_next     = req.position;
                    prev_next    = ale_pkg::NIL;
                    cur_next     = list_head_reg;
                    n_next       = '0;
                    status_next  = ale_pkg::ST_DONE;
                    slot_next    = ale_pkg::NIL;
                    removed_next = '0;
                    unique case (req.operation)
                        ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_REAR,
                        ale_pkg::OP_INS_AT, ale_pkg::OP_INS_SORTED:
                        begin
                            if (free_head_reg >= ale_pkg::NIL)
                            begin
                                status_next = ale_pkg::ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        ale_pkg::OP_DEL_FRONT, ale_pkg::OP_DEL_REAR, ale_pkg::OP_DEL_AT:
                        begin
                            if (list_head_reg >= ale_pkg::NIL)
                            begin
                                status_next = ale_pkg::ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // The memories hold the node at cur; on a step the next read
                // goes straight to its link.
                if (advance)
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    n_next    = n_reg + IW'(1);
                    rd_addr   = link_rd[AW-1:0];
                end
                else if (is_insert)
                begin
                    rd_addr    = free_head_reg[AW-1:0];
                    state_next = S_INS_A;
                end
                else
                begin
                    nxt_next   = link_rd;
                    val_next   = $signed(val_rd);
                    state_next = S_DEL_A;
                end
            end

            S_INS_A:
            begin
                link_we        = 1'b1;
                link_waddr     = free_head_reg[AW-1:0];
                link_wdata     = cur_reg;
                val_we         = 1'b1;
                val_waddr      = free_head_reg[AW-1:0];
                slot_next      = free_head_reg;
                free_head_next = link_rd;
                state_next     = S_INS_B;
            end

            S_INS_B:
            begin
                if (prev_reg == ale_pkg::NIL)
                begin
                    list_head_next = slot_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[AW-1:0];
                    link_wdata = slot_reg;
                end
                state_next = S_DONE;
            end

            S_DEL_A:
            begin
                link_we        = 1'b1;
                link_waddr     = cur_reg[AW-1:0];
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                slot_next      = cur_reg;
                removed_next   = val_reg;
                state_next     = S_DEL_B;
            end

            S_DEL_B:
            begin
                if (prev_reg == ale_pkg::NIL)
                begin
                    list_head_next = nxt_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[AW-1:0];
                    link_wdata = nxt_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = status_reg;
                    rsp_slot_next    = slot_reg;
                    rsp_removed_next = removed_reg;
                    state_next       = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            list_head_reg <= ale_pkg::NIL;
            free_head_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        elem_reg        <= elem_next;
        pos_reg         <= pos_next;
        prev_reg        <= prev_next;
        cur_reg         <= cur_next;
        n_reg           <= n_next;
        nxt_reg         <= nxt_next;
        val_reg         <= val_next;
        status_reg      <= status_next;
        slot_reg        <= slot_next;
        removed_reg     <= removed_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_slot_reg    <= rsp_slot_next;
        rsp_removed_reg <= rsp_removed_next;
    end

endmodule

### hdl/ale_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ale_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/ale_walk_unit.sv
// Shared compare unit: decides whether the walk moves on by one more link.
// Depends on ale_pkg.
module ale_walk_unit (
    input  ale_pkg::walk_in_t walk,
    output logic              advance
);

    logic cur_ok;
    logic link_ok;
    logic n_ok;
    logic pos_ok;
    logic greater;

    assign cur_ok  = walk.cur < ale_pkg::NIL;
    assign link_ok = walk.link < ale_pkg::NIL;
    assign n_ok    = walk.n < ale_pkg::NIL;
    assign pos_ok  = ale_pkg::CMP_W'(walk.n) < ale_pkg::CMP_W'(walk.pos);
    assign greater = walk.elem > walk.value;

    always_comb
    begin
        // Inserts stop on the node that will follow the new one; deletes stop
        // on the node to be removed, so they look one link ahead.
        unique case (walk.op)
            ale_pkg::OP_INS_REAR:   advance = cur_ok && n_ok;
            ale_pkg::OP_INS_AT:     advance = cur_ok && n_ok && pos_ok;
            ale_pkg::OP_INS_SORTED: advance = cur_ok && n_ok && greater;
            ale_pkg::OP_DEL_REAR:   advance = link_ok && n_ok;
            ale_pkg::OP_DEL_AT:     advance = link_ok && n_ok && pos_ok;
            default:                advance = 1'b0;
        endcase
    end

endmodule

### hdl/ale_checker.sv
// Port-level assertions for the array linked list engine, bound to the top level.
// Depends on ale_pkg and array_linked_list_engine_core.
module ale_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [ale_pkg::STATUS_W-1:0]      rsp_status,
    input logic [ale_pkg::IDX_W-1:0]         rsp_slot_index,
    input logic signed [ale_pkg::ELEM_W-1:0] rsp_removed_value
);

    // A result that is not taken stays in place.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_slot_index) && $stable(rsp_removed_value))
        else $error("response changed while stalled");

    // An accepted request always leaves the idle state, so no request directly follows one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken in the cycle after a transfer");

    // An ignored insert or delete names no slot and returns no value.
    a_ignored_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ale_pkg::ST_FULL || rsp_status == ale_pkg::ST_EMPTY)
            |-> rsp_slot_index == ale_pkg::NIL && rsp_removed_value == '0)
        else $error("ignored operation reports a slot or a value");

    // A value is returned only together with a freed slot.
    a_value_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_slot_index == ale_pkg::NIL |-> rsp_removed_value == '0)
        else $error("removed value without a freed slot");

endmodule

bind array_linked_list_engine_core ale_checker u_ale_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_slot_index    (rsp.slot_index),
    .rsp_removed_value (rsp.removed_value)
);

### sim/array_linked_list_engine_core_tb.sv
// Testbench of array_linked_list_engine_core: random and directed list operations.
// Depends on ale_pkg, ale_req_if and ale_rsp_if. It predicts every result with its
// own copy of the node store and the free list.
module array_linked_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = ale_pkg::ELEM_W;
    localparam int PW = ale_pkg::POS_W;
    localparam int IW = ale_pkg::IDX_W;
    localparam int AW = ale_pkg::ADDR_W;

    typedef struct {
        ale_pkg::op_t         op;
        logic signed [EW-1:0] elem;
        logic [PW-1:0]        pos;
    } list_cmd_t;

    typedef struct {
        logic [ale_pkg::STATUS_W-1:0] status;
        logic [IW-1:0]                slot_index;
        logic signed [EW-1:0]         removed_value;
    } list_result_t;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;

    ale_req_if req_ch();
    ale_rsp_if rsp_ch();

    array_linked_list_engine_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the node store.
    logic signed [EW-1:0] shadow_value [ale_pkg::NODE_COUNT];
    logic [IW-1:0]        shadow_link [ale_pkg::NODE_COUNT];
    logic [IW-1:0]        shadow_head;
    logic [IW-1:0]        shadow_free;

    list_cmd_t    cmd_queue[$];
    list_result_t result_queue[$];

    int send_idle;
    int recv_idle;
    int error_count;
    int hold_count;
    bit hold_request;
    int quiet_cycles;

    function automatic void clear_shadow();
        for (int i = 0; i < ale_pkg::NODE_COUNT; i++)
        begin
            shadow_value[AW'(i)] = '0;
            shadow_link[AW'(i)]  = IW'(i + 1);
        end
        shadow_head = ale_pkg::NIL;
        shadow_free = '0;
    endfunction

    // Applies one operation to the shadow list and returns the result it yields.
    function automatic list_result_t apply_list_op(list_cmd_t cmd);
        list_result_t res;
        logic [IW-1:0] prev;
        logic [IW-1:0] cur;
        logic [IW-1:0] slot;
        int n;
        res.status        = ale_pkg::ST_DONE;
        res.slot_index    = ale_pkg::NIL;
        res.removed_value = '0;
        prev = ale_pkg::NIL;
        n = 0;
        case (cmd.op)
            ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_REAR, ale_pkg::OP_INS_AT,
            ale_pkg::OP_INS_SORTED:
            begin
                if (shadow_free == ale_pkg::NIL)
                    res.status = ale_pkg::ST_FULL;
                else
                begin
                    cur = shadow_head;
                    if (cmd.op == ale_pkg::OP_INS_REAR)
                    begin
                        while (cur != ale_pkg::NIL && n < ale_pkg::NODE_COUNT)
                        begin
                            prev = cur;
                            cur = shadow_link[cur[AW-1:0]];
                            n++;
                        end
                    end
                    else if (cmd.op == ale_pkg::OP_INS_AT)
                    begin
                        while (cur != ale_pkg::NIL && n < cmd.pos && n < ale_pkg::NODE_COUNT)
                        begin
                            prev = cur;
                            cur = shadow_link[cur[AW-1:0]];
                            n++;
                        end
                    end
                    else if (cmd.op == ale_pkg::OP_INS_SORTED)
                    begin
                        while (cur != ale_pkg::NIL && n < ale_pkg::NODE_COUNT
                               && cmd.elem > shadow_value[cur[AW-1:0]])
                        begin
                            prev = cur;
                            cur = shadow_link[cur[AW-1:0]];
                            n++;
                        end
                    end
                    slot = shadow_free;
                    shadow_free = shadow_link[slot[AW-1:0]];
                    shadow_value[slot[AW-1:0]] = cmd.elem;
                    shadow_link[slot[AW-1:0]] = (prev == ale_pkg::NIL) ? shadow_head
                                                : shadow_link[prev[AW-1:0]];
                    if (prev == ale_pkg::NIL)
                        shadow_head = slot;
                    else
                        shadow_link[prev[AW-1:0]] = slot;
                    res.slot_index = slot;
                end
            end
            ale_pkg::OP_DEL_FRONT, ale_pkg::OP_DEL_REAR, ale_pkg::OP_DEL_AT:
            begin
                if (shadow_head == ale_pkg::NIL)
                    res.status = ale_pkg::ST_EMPTY;
                else
                begin
                    cur = shadow_head;
                    if (cmd.op == ale_pkg::OP_DEL_REAR)
                    begin
                        while (shadow_link[cur[AW-1:0]] != ale_pkg::NIL
                               && n < ale_pkg::NODE_COUNT)
                        begin
                            prev = cur;
                            cur = shadow_link[cur[AW-1:0]];
                            n++;
                        end
                    end
                    else if (cmd.op == ale_pkg::OP_DEL_AT)
                    begin
                        while (shadow_link[cur[AW-1:0]] != ale_pkg::NIL && n < cmd.pos
                               && n < ale_pkg::NODE_COUNT)
                        begin
                            prev = cur;
                            cur = shadow_link[cur[AW-1:0]];
                            n++;
                        end
                    end
                    slot = cur;
                    if (prev == ale_pkg::NIL)
                        shadow_head = shadow_link[slot[AW-1:0]];
                    else
                        shadow_link[prev[AW-1:0]] = shadow_link[slot[AW-1:0]];
                    shadow_link[slot[AW-1:0]] = shadow_free;
                    shadow_free = slot;
                    res.slot_index = slot;
                    res.removed_value = shadow_value[slot[AW-1:0]];
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_cmd(ale_pkg::op_t op, logic signed [EW-1:0] elem, logic [PW-1:0] pos);
        list_cmd_t cmd;
        cmd.op   = op;
        cmd.elem = elem;
        cmd.pos  = pos;
        cmd_queue.push_back(cmd);
    endtask

    // The insert share swings between phases so the list fills up and drains again.
    task automatic queue_random_cmds(int count);
        int insert_share;
        ale_pkg::op_t op;
        logic signed [EW-1:0] elem;
        logic [PW-1:0] pos;
        insert_share = 80;
        for (int i = 0; i < count; i++)
        begin
            if (i % 48 == 47)
                insert_share = (insert_share > 50) ? 25 : 80;
            if ($urandom_range(99) < insert_share)
                op = ale_pkg::op_t'($urandom_range(3, 0));
            else
                op = ale_pkg::op_t'($urandom_range(6, 4));
            case ($urandom_range(3))
                0: elem = EW'($urandom_range(6)) - 8'sd3;
                1: elem = $urandom_range(1) ? 8'sh7f : 8'sh80;
                default: elem = EW'($urandom_range(255));
            endcase
            pos = ($urandom_range(9) == 0) ? PW'(16) : PW'($urandom_range(16));
            queue_cmd(op, elem, pos);
        end
    endtask

    task automatic wait_until_drained();
        while (cmd_queue.size() != 0 || req_ch.valid || result_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = '0;
        req_ch.element = '0;
        req_ch.position = '0;
        rsp_ch.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: offers the next queued command and predicts each accepted one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                list_cmd_t taken;
                taken.op   = ale_pkg::op_t'(req_ch.operation);
                taken.elem = req_ch.element;
                taken.pos  = req_ch.position;
                result_queue.push_back(apply_list_op(taken));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    list_cmd_t nxt;
                    nxt = cmd_queue.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= nxt.op;
                    req_ch.element   <= nxt.elem;
                    req_ch.position  <= nxt.pos;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer and throttles ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                list_result_t want;
                if (result_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result status=%0d slot=%0d removed=%0d", $time,
                             rsp_ch.status, rsp_ch.slot_index, rsp_ch.removed_value);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, rsp_ch.status);
                    end
                    if (rsp_ch.slot_index !== want.slot_index)
                    begin
                        error_count++;
                        $display("%0t: slot_index expected %0d actual %0d", $time,
                                 want.slot_index, rsp_ch.slot_index);
                    end
                    if (rsp_ch.removed_value !== want.removed_value)
                    begin
                        error_count++;
                        $display("%0t: removed_value expected %0d actual %0d", $time,
                                 want.removed_value, rsp_ch.removed_value);
                    end
                end
            end
            if (hold_count > 0)
            begin
                hold_count--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_count = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [EW-1:0] fill_value;
        error_count = 0;
        quiet_cycles = 0;
        hold_count = 0;
        hold_request = 1'b0;
        send_idle = 11;
        recv_idle = 61;
        clear_shadow();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Deletes on the empty list, then every insert kind and its corner cases.
        queue_cmd(ale_pkg::OP_DEL_FRONT, 8'sh00, 5'd0);
        queue_cmd(ale_pkg::OP_DEL_REAR, 8'sh7f, 5'd0);
        queue_cmd(ale_pkg::OP_DEL_AT, 8'sh80, 5'd16);
        queue_cmd(ale_pkg::OP_INS_FRONT, 8'sh7f, 5'd0);
        queue_cmd(ale_pkg::OP_INS_REAR, 8'sh80, 5'd31);
        queue_cmd(ale_pkg::OP_INS_AT, 8'sh00, 5'd0);
        queue_cmd(ale_pkg::OP_INS_AT, 8'sh01, 5'd16);
        queue_cmd(ale_pkg::OP_INS_SORTED, -8'sd1, 5'd0);
        queue_cmd(ale_pkg::OP_INS_SORTED, 8'sh7f, 5'd0);
        queue_cmd(ale_pkg::OP_INS_SORTED, 8'sh80, 5'd0);
        for (int i = 0; i < 9; i++)
        begin
            fill_value = EW'(i * 20 - 80);
            queue_cmd(ale_pkg::OP_INS_SORTED, fill_value, 5'd0);
        end
        // The store is full now, so each insert kind must be refused.
        queue_cmd(ale_pkg::OP_INS_FRONT, 8'sh55, 5'd0);
        queue_cmd(ale_pkg::OP_INS_REAR, 8'sh55, 5'd0);
        queue_cmd(ale_pkg::OP_INS_AT, 8'sh55, 5'd3);
        queue_cmd(ale_pkg::OP_INS_SORTED, 8'sh55, 5'd0);
        // Delete past the end removes the last node.
        queue_cmd(ale_pkg::OP_DEL_AT, 8'sh00, 5'd16);
        queue_cmd(ale_pkg::OP_DEL_AT, 8'sh00, 5'd0);
        queue_cmd(ale_pkg::OP_DEL_AT, 8'sh00, 5'd5);
        queue_cmd(ale_pkg::OP_DEL_REAR, 8'sh00, 5'd0);
        queue_cmd(ale_pkg::OP_DEL_FRONT, 8'sh00, 5'd0);
        queue_random_cmds(480);
        wait_until_drained();

        // Long receiver hold-off while commands keep coming, so the input stalls.
        hold_request = 1'b1;
        queue_random_cmds(40);
        wait_until_drained();

        send_idle = 61;
        recv_idle = 11;
        queue_random_cmds(480);
        wait_until_drained();

        send_idle = 0;
        recv_idle = 0;
        queue_random_cmds(480);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && result_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
